>>> rtl/scr_pkg.sv
`timescale 1ns / 1ps
package scr_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CNT_W   = 30;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned ODATA_W = 40;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  localparam logic [WORD_W-1:0] DELIM_WORD     = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] REBUILT_LEN    = 32'd2;
  localparam logic [WORD_W-1:0] REBUILT_ID     = 32'd9999;
  localparam logic [7:0]        MAX_CHUNKS_RST = 8'd200;
  localparam logic [CNT_W-1:0]  END_CHUNK_WDS  = 30'd5;
  localparam logic [CNT_W-1:0]  HEAD_WDS       = 30'd3;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_TOTAL   = 3'd1;
  localparam logic [2:0] PH_NUMBER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_DELIM   = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;
  localparam logic [2:0] PH_DROP    = 3'd6;

  localparam logic [KIND_W-1:0] K_PAYLOAD    = 2'd0;
  localparam logic [KIND_W-1:0] K_COMPLETE   = 2'd1;
  localparam logic [KIND_W-1:0] K_INCOMPLETE = 2'd2;
  localparam logic [KIND_W-1:0] K_DROPPED    = 2'd3;

  localparam logic [ERR_W-1:0] E_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] E_TOTAL     = 3'd1;
  localparam logic [ERR_W-1:0] E_RANGE     = 3'd2;
  localparam logic [ERR_W-1:0] E_SHORT     = 3'd3;
  localparam logic [ERR_W-1:0] E_SYNC_DLM  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] data;
    logic [ERR_W-1:0]  err;
    logic              last;
  } res_t;

endpackage

>>> rtl/spill_chunk_reassembler.sv
`timescale 1ns / 1ps
// Results are written to the result queue as their word is accepted; out_* shows its head.
// Throughput: one word per cycle while out_tready takes results and each word makes at
// most one result; a word that makes three results (rebuilt terminator) holds intake
// until the four-entry result queue drains to one entry.
// Reset (rst_n low, synchronous): empty queue, parser waits for a header word, sync pending.
module spill_chunk_reassembler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [scr_pkg::WORD_W-1:0]    in_tdata,   // [31:0] word
  input  logic                          in_tlast,   // last_of_packet
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [scr_pkg::ODATA_W-1:0]   out_tdata,  // [31:0] data_word, [34:32] error_code
  output logic [scr_pkg::KIND_W-1:0]    out_tuser,  // kind
  output logic                          out_tlast,  // last
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_wdata   // max_chunks
);
  import scr_pkg::*;

  logic [7:0]        max_r;
  logic [2:0]        phase_r, phase_nxt;
  logic [CNT_W-1:0]  wl_r, wl_nxt;
  logic [CNT_W-1:0]  cw_r, cw_nxt;
  logic [WORD_W-1:0] ctot_r, ctot_nxt;
  logic [WORD_W-1:0] ptot_r, ptot_nxt;
  logic [WORD_W-1:0] cnum_r, cnum_nxt;
  logic [WORD_W-1:0] prev_r, prev_nxt;
  logic              pv_r, pv_nxt;
  logic [7:0]        cis_r, cis_nxt;
  logic              sync_r, sync_nxt;
  logic              pstart_r, pstart_nxt;
  logic              hd_r, hd_nxt;

  res_t              q_r [Q_DEPTH];
  logic [Q_AW-1:0]   wp_r, rp_r;
  logic [Q_AW:0]     cnt_r;

  res_t              res [3];
  logic [1:0]        n;
  logic              drop_req;
  logic [ERR_W-1:0]  drop_err;
  logic              in_acc, out_acc;
  logic [WORD_W-1:0] w;
  res_t              head;

  assign w         = in_tdata;
  assign in_tready = (cnt_r <= (Q_AW+1)'(1));
  assign in_acc    = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_acc   = out_tvalid && out_tready;
  assign head      = q_r[rp_r];
  assign out_tdata = {{(ODATA_W-WORD_W-ERR_W){1'b0}}, head.err, head.data};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  always_comb begin
    phase_nxt  = phase_r;
    wl_nxt     = wl_r;
    cw_nxt     = cw_r;
    ctot_nxt   = ctot_r;
    ptot_nxt   = ptot_r;
    cnum_nxt   = cnum_r;
    prev_nxt   = prev_r;
    pv_nxt     = pv_r;
    cis_nxt    = cis_r;
    sync_nxt   = sync_r;
    pstart_nxt = pstart_r;
    hd_nxt     = hd_r;
    n          = 2'd0;
    drop_req   = 1'b0;
    drop_err   = E_NONE;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    if (in_acc) begin
      unique case (phase_r)
        PH_HEADER: begin
          cw_nxt = w[WORD_W-1:2];
          hd_nxt = (w == DELIM_WORD);
          if (!pstart_r && (w == DELIM_WORD)) begin
            if (sync_r) begin
              drop_req = 1'b1;
              drop_err = E_SYNC_DLM;
            end else begin
              phase_nxt = PH_DROP;
            end
          end else begin
            phase_nxt = PH_TOTAL;
          end
        end
        PH_TOTAL: begin
          ptot_nxt  = w;
          phase_nxt = PH_NUMBER;
          if (pstart_r) begin
            if (w > {24'd0, max_r}) begin
              drop_req = 1'b1;
              drop_err = E_TOTAL;
            end else begin
              ctot_nxt = w;
            end
          end
        end
        PH_NUMBER: begin
          pstart_nxt = 1'b0;
          if (sync_r && (!pstart_r || (w != '0))) begin
            if (hd_r) begin
              drop_req = 1'b1;
              drop_err = E_SYNC_DLM;
            end else begin
              ctot_nxt = ptot_r;
              cnum_nxt = w;
              if (cw_r < HEAD_WDS) begin
                drop_req = 1'b1;
                drop_err = E_SHORT;
              end else begin
                wl_nxt    = cw_r - (HEAD_WDS - 30'd1);
                phase_nxt = PH_SKIP;
              end
            end
          end else begin
            sync_nxt = 1'b0;
            if (hd_r) begin
              phase_nxt = PH_DROP;
            end else begin
              if (pv_r && (w != prev_r + 32'd1)) begin
                if ((prev_r + 32'd2 == ctot_r) && ({24'd0, cis_r} == ctot_r - 32'd1)) begin
                  res[0] = '{kind: K_PAYLOAD, data: REBUILT_LEN, err: E_NONE, last: 1'b0};
                  res[1] = '{kind: K_PAYLOAD, data: REBUILT_ID, err: E_NONE, last: 1'b0};
                  res[2] = '{kind: K_COMPLETE, data: '0, err: E_NONE, last: 1'b0};
                  n       = 2'd3;
                  cis_nxt = '0;
                  pv_nxt  = 1'b0;
                end else if (w == '0) begin
                  res[0]  = '{kind: K_INCOMPLETE, data: '0, err: E_NONE, last: 1'b0};
                  n       = 2'd1;
                  cis_nxt = '0;
                  pv_nxt  = 1'b0;
                end
              end
              ctot_nxt = ptot_r;
              if (ptot_r > {24'd0, max_r}) begin
                drop_req = 1'b1;
                drop_err = E_TOTAL;
              end else if (w > ptot_r - 32'd1) begin
                drop_req = 1'b1;
                drop_err = E_RANGE;
              end else begin
                prev_nxt = w;
                pv_nxt   = 1'b1;
                cnum_nxt = w;
                if (cis_nxt != 8'hFF) begin
                  cis_nxt = cis_nxt + 8'd1;
                end
                if (cw_r < HEAD_WDS) begin
                  drop_req = 1'b1;
                  drop_err = E_SHORT;
                end else begin
                  wl_nxt    = cw_r - HEAD_WDS;
                  phase_nxt = (cw_r != HEAD_WDS) ? PH_PAYLOAD : PH_DELIM;
                end
              end
            end
          end
        end
        PH_PAYLOAD: begin
          res[0] = '{kind: K_PAYLOAD, data: w, err: E_NONE, last: 1'b0};
          n      = 2'd1;
          wl_nxt = wl_r - 30'd1;
          if (wl_r == 30'd1) begin
            phase_nxt = PH_DELIM;
          end
        end
        PH_DELIM: begin
          if ((cw_r == END_CHUNK_WDS) && (cnum_r == ctot_r - 32'd1)) begin
            res[0].kind = ({24'd0, cis_r} == ctot_r) ? K_COMPLETE : K_INCOMPLETE;
            n       = 2'd1;
            cis_nxt = '0;
            pv_nxt  = 1'b0;
          end
          phase_nxt = PH_HEADER;
        end
        PH_SKIP: begin
          wl_nxt = wl_r - 30'd1;
          if (wl_r == 30'd1) begin
            if (cw_r == END_CHUNK_WDS) begin
              sync_nxt = 1'b0;
            end
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
        end
      endcase
      if (drop_req) begin
        phase_nxt = PH_DROP;
        if (n == 2'd3) begin
          res[2].err = drop_err;
        end else begin
          res[n] = '{kind: K_DROPPED, data: '0, err: drop_err, last: 1'b0};
          n      = n + 2'd1;
        end
      end
      if (in_tlast) begin
        phase_nxt  = PH_HEADER;
        pstart_nxt = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        res[i].last = (n == 2'(i + 1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r    <= MAX_CHUNKS_RST;
      phase_r  <= PH_HEADER;
      wl_r     <= '0;
      cw_r     <= '0;
      ctot_r   <= '0;
      ptot_r   <= '0;
      cnum_r   <= '0;
      prev_r   <= '0;
      pv_r     <= 1'b0;
      cis_r    <= '0;
      sync_r   <= 1'b1;
      pstart_r <= 1'b1;
      hd_r     <= 1'b0;
      wp_r     <= '0;
      rp_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      phase_r  <= phase_nxt;
      wl_r     <= wl_nxt;
      cw_r     <= cw_nxt;
      ctot_r   <= ctot_nxt;
      ptot_r   <= ptot_nxt;
      cnum_r   <= cnum_nxt;
      prev_r   <= prev_nxt;
      pv_r     <= pv_nxt;
      cis_r    <= cis_nxt;
      sync_r   <= sync_nxt;
      pstart_r <= pstart_nxt;
      hd_r     <= hd_nxt;
      wp_r     <= wp_r + Q_AW'(n);
      if (out_acc) begin
        rp_r <= rp_r + Q_AW'(1);
      end
      cnt_r <= cnt_r + (Q_AW+1)'(n) - (Q_AW+1)'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n) begin
        q_r[wp_r + Q_AW'(i)] <= res[i];
      end
    end
  end

endmodule

>>> rtl/scr_checker.sv
`timescale 1ns / 1ps
module scr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [scr_pkg::ODATA_W-1:0] out_tdata,
  input logic [scr_pkg::KIND_W-1:0]  out_tuser,
  input logic                        out_tlast
);
  import scr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  a_mark_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != K_PAYLOAD) |-> out_tdata[WORD_W-1:0] == '0)
    else $error("mark item carries data");

  a_payload_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == K_PAYLOAD || out_tuser == K_INCOMPLETE)
      |-> out_tdata[WORD_W+ERR_W-1:WORD_W] == E_NONE)
    else $error("error code on payload or incomplete item");

  a_drop_has_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == K_DROPPED) |-> out_tdata[WORD_W+ERR_W-1:WORD_W] != E_NONE
      && out_tlast)
    else $error("drop item without error code or not last");

endmodule

bind spill_chunk_reassembler scr_checker u_scr_checker (.*);

>>> bench/tb_spill_chunk_reassembler.sv
`timescale 1ns / 1ps
module tb_spill_chunk_reassembler;
  import scr_pkg::*;

  localparam int unsigned MOST_RESULTS = 3;
  localparam logic [32:0] EOP = 33'h1_0000_0000;
  localparam logic [32:0] DLM = {1'b0, DELIM_WORD};

  class chunk_stream_checker;
    logic [7:0]  max_chunks;
    logic [2:0]  phase;
    logic [31:0] words_left;
    logic [31:0] chunk_words;
    logic [31:0] chunk_total;
    logic [31:0] pending_total;
    logic [31:0] chunk_number;
    logic [31:0] previous_number;
    logic [7:0]  chunks_in_spill;
    bit          prev_valid;
    bit          syncing;
    bit          packet_start;
    bit          header_delim;
    res_t        word_results[$];
    res_t        awaited_results[$];
    int unsigned fail_count;

    function new();
      max_chunks      = MAX_CHUNKS_RST;
      phase           = PH_HEADER;
      words_left      = '0;
      chunk_words     = '0;
      chunk_total     = '0;
      pending_total   = '0;
      chunk_number    = '0;
      previous_number = '0;
      chunks_in_spill = '0;
      prev_valid      = 1'b0;
      syncing         = 1'b1;
      packet_start    = 1'b1;
      header_delim    = 1'b0;
      fail_count      = 0;
    endfunction

    function void emit(logic [KIND_W-1:0] k, logic [WORD_W-1:0] d, logic [ERR_W-1:0] e);
      if (word_results.size() >= MOST_RESULTS) return;
      word_results.push_back('{kind: k, data: d, err: e, last: 1'b0});
    endfunction

    // a rebuilt terminator leaves no room: the drop code lands on its mark
    function void drop_packet(logic [ERR_W-1:0] e);
      phase = PH_DROP;
      if (word_results.size() >= MOST_RESULTS) begin
        word_results[word_results.size()-1].err = e;
      end else begin
        emit(K_DROPPED, '0, e);
      end
    endfunction

    function void restart_spill();
      chunks_in_spill = '0;
      prev_valid      = 1'b0;
    endfunction

    function void take_number(logic [31:0] num);
      bit first;
      first = packet_start;
      packet_start = 1'b0;
      if (syncing && (!first || num != 32'd0)) begin
        if (header_delim) begin
          drop_packet(E_SYNC_DLM);
          return;
        end
        chunk_total  = pending_total;
        chunk_number = num;
        if (chunk_words < HEAD_WDS) begin
          drop_packet(E_SHORT);
          return;
        end
        words_left = chunk_words - (HEAD_WDS - 30'd1);
        phase = PH_SKIP;
        return;
      end
      syncing = 1'b0;
      if (header_delim) begin
        phase = PH_DROP;
        return;
      end
      if (prev_valid && num != previous_number + 32'd1) begin
        if (previous_number + 32'd2 == chunk_total &&
            chunks_in_spill == chunk_total - 32'd1) begin
          emit(K_PAYLOAD, REBUILT_LEN, E_NONE);
          emit(K_PAYLOAD, REBUILT_ID, E_NONE);
          emit(K_COMPLETE, '0, E_NONE);
          restart_spill();
        end else if (num == 32'd0) begin
          emit(K_INCOMPLETE, '0, E_NONE);
          restart_spill();
        end
      end
      chunk_total = pending_total;
      if (chunk_total > max_chunks) begin
        drop_packet(E_TOTAL);
        return;
      end
      if (num > chunk_total - 32'd1) begin
        drop_packet(E_RANGE);
        return;
      end
      previous_number = num;
      prev_valid      = 1'b1;
      chunk_number    = num;
      if (chunks_in_spill != 8'hFF) chunks_in_spill++;
      if (chunk_words < HEAD_WDS) begin
        drop_packet(E_SHORT);
        return;
      end
      words_left = chunk_words - HEAD_WDS;
      phase = (words_left != 32'd0) ? PH_PAYLOAD : PH_DELIM;
    endfunction

    function void accept_word(logic [31:0] w, logic lastp);
      word_results.delete();
      case (phase)
        PH_HEADER: begin
          chunk_words  = {2'b00, w[31:2]};
          header_delim = (w == DELIM_WORD);
          if (!packet_start && header_delim) begin
            if (syncing) drop_packet(E_SYNC_DLM);
            else phase = PH_DROP;
          end else begin
            phase = PH_TOTAL;
          end
        end
        PH_TOTAL: begin
          pending_total = w;
          phase = PH_NUMBER;
          if (packet_start) begin
            if (w > max_chunks) drop_packet(E_TOTAL);
            else chunk_total = w;
          end
        end
        PH_NUMBER: take_number(w);
        PH_PAYLOAD: begin
          emit(K_PAYLOAD, w, E_NONE);
          words_left--;
          if (words_left == 32'd0) phase = PH_DELIM;
        end
        PH_DELIM: begin
          if (chunk_words == END_CHUNK_WDS && chunk_number == chunk_total - 32'd1) begin
            emit((chunks_in_spill == chunk_total) ? K_COMPLETE : K_INCOMPLETE, '0, E_NONE);
            restart_spill();
          end
          phase = PH_HEADER;
        end
        PH_SKIP: begin
          words_left--;
          if (words_left == 32'd0) begin
            if (chunk_words == END_CHUNK_WDS) syncing = 1'b0;
            phase = PH_HEADER;
          end
        end
        default: ;
      endcase
      if (lastp) begin
        phase = PH_HEADER;
        packet_start = 1'b1;
      end
      if (word_results.size() > 0) word_results[word_results.size()-1].last = 1'b1;
      foreach (word_results[i]) awaited_results.push_back(word_results[i]);
    endfunction

    function void report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        fail_count++;
        if (fail_count <= 40) $error("%s: expected %0h, actual %0h", name, want, got);
      end
    endfunction

    function void compare_result(res_t got);
      res_t want;
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 40)
          $error("unexpected result: kind %0d data %0h error_code %0d",
                 got.kind, got.data, got.err);
        return;
      end
      want = awaited_results.pop_front();
      report_field("kind", want.kind, got.kind);
      report_field("data_word", want.data, got.data);
      report_field("error_code", want.err, got.err);
      report_field("last", want.last, got.last);
    endfunction
  endclass

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [WORD_W-1:0]   in_tdata   = '0;
  logic                in_tlast   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [ODATA_W-1:0]  out_tdata;
  logic [KIND_W-1:0]   out_tuser;
  logic                out_tlast;
  logic                cfg_we     = 1'b0;
  logic [7:0]          cfg_wdata  = '0;

  chunk_stream_checker sb = new();
  res_t        seen;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned items_sent   = 0;
  int unsigned next_num     = 0;
  int unsigned spill_total  = 0;
  logic [32:0] opening[$];

  spill_chunk_reassembler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("spill_chunk_reassembler test failed");
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 199;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.kind = out_tuser;
      seen.data = out_tdata[31:0];
      seen.err  = out_tdata[34:32];
      seen.last = out_tlast;
      sb.compare_result(seen);
    end
  end

  task automatic send_word(input logic [31:0] w, input logic lastp);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tlast  <= lastp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.accept_word(w, lastp);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic set_max_chunks(input logic [7:0] v);
    in_tvalid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.max_chunks = v;
  endtask

  function automatic void start_spill();
    if ($urandom_range(0, 19) == 0) begin
      spill_total = $urandom_range(7, 255);
      next_num    = spill_total - $urandom_range(1, 3);
    end else begin
      spill_total = $urandom_range(1, 6);
      next_num    = 0;
    end
  endfunction

  task automatic send_spill_packet();
    logic [32:0] words[$];
    logic [31:0] hdr;
    logic [31:0] tot;
    logic [31:0] num;
    int unsigned n_chunks;
    int unsigned nw;
    int unsigned roll;
    int unsigned cut;
    bit          closing;
    n_chunks = $urandom_range(1, 4);
    repeat (n_chunks) begin
      roll = $urandom_range(0, 99);
      if (next_num >= spill_total) start_spill();
      if (roll < 8 && next_num == spill_total - 1) begin
        start_spill();
      end else if (roll >= 8 && roll < 13) begin
        next_num++;
        if (next_num >= spill_total) start_spill();
      end
      closing = (next_num == spill_total - 1);
      tot = spill_total;
      num = next_num;
      nw  = closing ? 5 : $urandom_range(3, 8);
      hdr = nw * 4 + $urandom_range(0, 3);
      if (roll >= 13 && roll < 25) begin
        case ($urandom_range(0, 4))
          0: hdr = $urandom_range(0, 11);
          1: hdr = $urandom;
          2: hdr = DELIM_WORD;
          3: tot = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 300);
          default: num = ($urandom_range(0, 1) != 0) ? $urandom : tot + $urandom_range(0, 3);
        endcase
      end
      words.push_back({1'b0, hdr});
      words.push_back({1'b0, tot});
      words.push_back({1'b0, num});
      for (int i = 3; i < nw; i++) begin
        if (closing) words.push_back({1'b0, (i == 3) ? REBUILT_LEN : REBUILT_ID});
        else words.push_back({1'b0, 32'($urandom)});
      end
      words.push_back(($urandom_range(0, 9) == 0) ? {1'b0, 32'($urandom)} : DLM);
      next_num++;
    end
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      words.push_back(DLM);
    end else if (roll == 2) begin
      cut = $urandom_range(1, words.size());
      while (words.size() > cut) void'(words.pop_back());
    end
    words[words.size()-1][32] = 1'b1;
    foreach (words[i]) send_word(words[i][31:0], words[i][32]);
  endtask

  task automatic send_random(input int unsigned n);
    int unsigned target;
    target = items_sent + n;
    while (items_sent < target) send_spill_packet();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    snd_idle_pct = 12;
    rcv_idle_pct = 66;
    opening = '{33'd12, 33'd3, 33'd1, DLM, DLM | EOP,
                33'd8, 33'd3, 33'd2 | EOP,
                33'd16, 33'd4, 33'd3, 33'hA5A5_5A5A, DLM,
                33'd12, 33'd2, 33'd0, DLM,
                33'd20, 33'd2, 33'd1, 33'd0, 33'hFFFF_FFFE, DLM,
                33'd20, 33'd1, 33'd0, 33'd2, 33'd9999, DLM | EOP};
    foreach (opening[i]) send_word(opening[i][31:0], opening[i][32]);
    send_random(40);

    set_max_chunks(8'd255);
    snd_idle_pct = 66;
    rcv_idle_pct = 12;
    send_random(25);

    set_max_chunks(8'd1);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_request = 1'b1;
    send_random(20);

    set_max_chunks(8'd3);
    send_random(20);

    in_tvalid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("spill_chunk_reassembler test passed");
    end else begin
      $display("spill_chunk_reassembler test failed");
    end
    $finish;
  end

endmodule
